// ===== design/cbe_pkg.sv =====
package cbe_pkg;

  localparam int unsigned WORD_BITS   = 64;
  localparam int unsigned BIT_W       = 6;
  localparam int unsigned DEF_NBITS   = 4096;
  localparam int unsigned POS_W       = 16;
  localparam int unsigned WIDX_W      = POS_W - BIT_W;
  localparam int unsigned COUNT_OUT_W = 13;
  localparam int unsigned FPOS_W      = 12;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPW         = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    KIND_TEST        = 3'd0,
    KIND_TEST_SET    = 3'd1,
    KIND_TEST_CLEAR  = 3'd2,
    KIND_ZERO_ALL    = 3'd3,
    KIND_FILL_ALL    = 3'd4,
    KIND_INVERT_ALL  = 3'd5,
    KIND_FIRST_ZERO  = 3'd6,
    KIND_FIRST_ONE   = 3'd7
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    logic [POS_W-1:0] position;
  } cbe_cmd_t;

  typedef struct packed {
    logic                   old_bit;
    logic                   out_of_range;
    logic                   found;
    logic [FPOS_W-1:0]      found_position;
    logic [COUNT_OUT_W-1:0] ones_count;
    logic                   is_empty;
    logic                   is_full;
  } cbe_res_t;

  // classified word handed from front to back
  typedef struct packed {
    kind_e             kind;
    logic              oor;
    logic [WIDX_W-1:0] word;
    logic [BIT_W-1:0]  offset;
  } cbe_op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } cbe_qstat_t;

  function automatic logic [2:0] lowest8(input logic [7:0] b);
    logic [2:0] idx;
    idx = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (b[i]) begin
        idx = 3'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ===== design/cbe_front.sv =====
module cbe_front
  import cbe_pkg::*;
#(
  parameter int unsigned NBITS = DEF_NBITS
) (
  input  logic       start,
  output logic       busy,
  input  cbe_cmd_t   cmd_i,
  input  cbe_qstat_t qstat_i,
  input  logic       clearing_i,
  output logic       push_o,
  output cbe_op_t    item_o
);

  logic single;

  assign busy   = qstat_i.full | clearing_i;
  assign push_o = start & ~busy;

  assign single = (cmd_i.kind == KIND_TEST) || (cmd_i.kind == KIND_TEST_SET) ||
                  (cmd_i.kind == KIND_TEST_CLEAR);

  always_comb begin
    item_o.kind   = cmd_i.kind;
    item_o.oor    = single && ({1'b0, cmd_i.position} >= (POS_W + 1)'(NBITS));
    item_o.word   = cmd_i.position[POS_W-1:BIT_W];
    item_o.offset = cmd_i.position[BIT_W-1:0];
  end

endmodule

// ===== design/cbe_queue.sv =====
module cbe_queue
  import cbe_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  cbe_op_t    item_i,
  input  logic       pop_i,
  output cbe_op_t    head_o,
  output cbe_qstat_t qstat_o
);

  cbe_op_t        slot_q [QUEUE_DEPTH];
  logic [QPW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPW:0]   fill_q, fill_d;

  assign qstat_o.full  = (fill_q == (QPW + 1)'(QUEUE_DEPTH));
  assign qstat_o.empty = (fill_q == '0);
  assign head_o        = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPW'(1);
    end
    if (push_i && !pop_i) begin
      fill_d = fill_q + (QPW + 1)'(1);
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - (QPW + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

  a_no_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !qstat_o.full) else $error("push into full queue");
  a_no_pop_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !qstat_o.empty) else $error("pop from empty queue");
  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= (QPW + 1)'(QUEUE_DEPTH)) else $error("queue fill count overflow");

endmodule

// ===== design/cbe_back.sv =====
module cbe_back
  import cbe_pkg::*;
#(
  parameter int unsigned NBITS = DEF_NBITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cbe_qstat_t qstat_i,
  input  cbe_op_t    head_i,
  output logic       pop_o,
  output logic       clearing_o,
  output logic       done_o,
  output cbe_res_t   res_o
);

  localparam int unsigned NWORDS = NBITS / WORD_BITS;
  localparam int unsigned WAW    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int unsigned CNTW   = WAW + 1;
  localparam int unsigned CW     = $clog2(NBITS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SWEEP = 3'd1;
  localparam logic [2:0] S_BIT   = 3'd2;
  localparam logic [2:0] S_INV   = 3'd3;
  localparam logic [2:0] S_FIND  = 3'd4;

  logic [WORD_BITS-1:0] mem [NWORDS];
  logic [WORD_BITS-1:0] rdata_q;
  logic                 mem_we, mem_re;
  logic [WAW-1:0]       mem_waddr, mem_raddr;
  logic [WORD_BITS-1:0] mem_wdata;

  logic [2:0]      state_q, state_d;
  logic            clearing_q, clearing_d;
  logic            fill_one_q, fill_one_d;
  logic [CNTW-1:0] idx_q, idx_d;
  logic            pend_q, pend_d;
  logic [WAW-1:0]  pend_addr_q, pend_addr_d;
  logic [CW-1:0]   count_q, count_d;
  cbe_op_t         cur_q, cur_d;
  logic            f_v_q, f_v_d;
  logic [7:0]      f_nz_q, f_nz_d;
  logic [7:0][2:0] f_idx_q, f_idx_d;
  logic [WAW-1:0]  f_addr_q, f_addr_d;
  logic            res_valid_q, res_valid_d;
  cbe_res_t        res_q, res_d;

  always_comb begin
    logic                 old;
    logic                 skip;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] w;
    logic [2:0]           sel;
    state_d     = state_q;
    clearing_d  = clearing_q;
    fill_one_d  = fill_one_q;
    idx_d       = idx_q;
    pend_d      = pend_q;
    pend_addr_d = pend_addr_q;
    count_d     = count_q;
    cur_d       = cur_q;
    f_v_d       = f_v_q;
    f_nz_d      = f_nz_q;
    f_idx_d     = f_idx_q;
    f_addr_d    = f_addr_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    pop_o       = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = idx_q[WAW-1:0];
    mem_raddr   = idx_q[WAW-1:0];
    mem_wdata   = {WORD_BITS{fill_one_q}};
    old         = 1'b0;
    skip        = 1'b0;
    mask        = WORD_BITS'(1) << cur_q.offset;
    w           = '0;
    sel         = 3'd0;

    unique case (state_q)
      S_IDLE: begin
        if (!qstat_i.empty) begin
          pop_o                = 1'b1;
          cur_d                = head_i;
          res_d.old_bit        = 1'b0;
          res_d.out_of_range   = 1'b0;
          res_d.found          = 1'b0;
          res_d.found_position = '0;
          idx_d                = '0;
          pend_d               = 1'b0;
          f_v_d                = 1'b0;
          unique case (head_i.kind)
            KIND_TEST, KIND_TEST_SET, KIND_TEST_CLEAR: begin
              if (head_i.oor) begin
                res_valid_d        = 1'b1;
                res_d.out_of_range = 1'b1;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = head_i.word[WAW-1:0];
                state_d   = S_BIT;
              end
            end
            KIND_ZERO_ALL, KIND_FILL_ALL: begin
              fill_one_d  = (head_i.kind == KIND_FILL_ALL);
              count_d     = (head_i.kind == KIND_FILL_ALL) ? CW'(NBITS) : '0;
              res_valid_d = 1'b1;
              state_d     = S_SWEEP;
            end
            KIND_INVERT_ALL: begin
              count_d     = CW'(NBITS) - count_q;
              res_valid_d = 1'b1;
              state_d     = S_INV;
            end
            KIND_FIRST_ZERO, KIND_FIRST_ONE: begin
              skip = (head_i.kind == KIND_FIRST_ONE) ? (count_q == '0)
                                                     : (count_q == CW'(NBITS));
              if (skip) begin
                res_valid_d = 1'b1;
              end else begin
                state_d = S_FIND;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_SWEEP: begin
        mem_we = 1'b1;
        if (idx_q == CNTW'(NWORDS - 1)) begin
          clearing_d = 1'b0;
          state_d    = S_IDLE;
        end else begin
          idx_d = idx_q + CNTW'(1);
        end
      end

      S_BIT: begin
        old                = |(rdata_q & mask);
        mem_waddr          = cur_q.word[WAW-1:0];
        res_valid_d        = 1'b1;
        res_d.old_bit      = old;
        if (cur_q.kind == KIND_TEST_SET && !old) begin
          mem_we    = 1'b1;
          mem_wdata = rdata_q | mask;
          count_d   = count_q + CW'(1);
        end else if (cur_q.kind == KIND_TEST_CLEAR && old) begin
          mem_we    = 1'b1;
          mem_wdata = rdata_q & ~mask;
          count_d   = count_q - CW'(1);
        end
        state_d = S_IDLE;
      end

      S_INV: begin
        if (idx_q < CNTW'(NWORDS)) begin
          mem_re      = 1'b1;
          pend_d      = 1'b1;
          pend_addr_d = idx_q[WAW-1:0];
          idx_d       = idx_q + CNTW'(1);
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = pend_addr_q;
          mem_wdata = ~rdata_q;
          if (pend_addr_q == WAW'(NWORDS - 1)) begin
            state_d = S_IDLE;
          end
        end
      end

      S_FIND: begin
        // read, per-byte scan, byte select
        if (idx_q < CNTW'(NWORDS)) begin
          mem_re      = 1'b1;
          pend_d      = 1'b1;
          pend_addr_d = idx_q[WAW-1:0];
          idx_d       = idx_q + CNTW'(1);
        end else begin
          pend_d = 1'b0;
        end
        w        = (cur_q.kind == KIND_FIRST_ONE) ? rdata_q : ~rdata_q;
        f_v_d    = pend_q;
        f_addr_d = pend_addr_q;
        for (int b = 0; b < 8; b++) begin
          f_nz_d[b]  = ((w >> (8 * b)) & WORD_BITS'(8'hFF)) != '0;
          f_idx_d[b] = lowest8(w[8*b +: 8]);
        end
        for (int b = 7; b >= 0; b--) begin
          if (f_nz_q[b]) begin
            sel = 3'(b);
          end
        end
        if (f_v_q && (f_nz_q != '0)) begin
          res_valid_d          = 1'b1;
          res_d.found          = 1'b1;
          res_d.found_position = FPOS_W'({f_addr_q, sel, f_idx_q[sel]});
          state_d              = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    res_d.ones_count = COUNT_OUT_W'(count_d);
    res_d.is_empty   = (count_d == '0);
    res_d.is_full    = (count_d == CW'(NBITS));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SWEEP;
      clearing_q  <= 1'b1;
      fill_one_q  <= 1'b0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      count_q     <= '0;
      f_v_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clearing_q  <= clearing_d;
      fill_one_q  <= fill_one_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      count_q     <= count_d;
      f_v_q       <= f_v_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_addr_q <= pend_addr_d;
    cur_q       <= cur_d;
    f_nz_q      <= f_nz_d;
    f_idx_q     <= f_idx_d;
    f_addr_q    <= f_addr_d;
    res_q       <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  assign clearing_o = clearing_q;
  assign done_o     = res_valid_q;
  assign res_o      = res_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(NBITS)) else $error("set-bit count above store size");
  a_find_no_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FIND |-> !mem_we) else $error("store written during a find");
  a_bit_one_cycle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_BIT |=> state_q == S_IDLE) else $error("single-bit op overran");
  a_no_result_clearing : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> !pop_o && !res_valid_d) else $error("work taken during clearing");

endmodule

// ===== design/counted_bitmap_engine_core.sv =====
// Bit store of NBITS bits held as 64-bit words in one memory, with a running
// set-bit count. A command word is taken when start is high and busy is low;
// a two-entry queue sits between the decode front and the executing back, so
// once the store is cleared after reset busy rises only when that queue is full.
// Each command gives one result word,
// shown on res_o for exactly one cycle while done_o is high; the receiver
// cannot stall it. The back works on one memory with one read and one write
// port: test/test-set/test-clear read the word and write it back if the bit
// changes, an out-of-range position or a find on an empty/full store is
// answered from the idle state without a memory access, zero-all and
// fill-all write every word in a sweep, invert-all is a read-modify-write
// sweep, and a find is a word scan through a two-stage byte search, stopping
// at the first hit. After reset a sweep zeroes the store while busy is held high.
module counted_bitmap_engine_core
  import cbe_pkg::*;
#(
  parameter int unsigned NBITS = DEF_NBITS
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  cbe_cmd_t cmd_i,
  output logic     done_o,
  output cbe_res_t res_o
);

  cbe_qstat_t qstat;
  cbe_op_t    push_item;
  cbe_op_t    head;
  logic       push;
  logic       pop;
  logic       clearing;

  cbe_front #(
    .NBITS(NBITS)
  ) u_front (
    .start     (start),
    .busy      (busy),
    .cmd_i     (cmd_i),
    .qstat_i   (qstat),
    .clearing_i(clearing),
    .push_o    (push),
    .item_o    (push_item)
  );

  cbe_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .pop_i  (pop),
    .head_o (head),
    .qstat_o(qstat)
  );

  cbe_back #(
    .NBITS(NBITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .qstat_i   (qstat),
    .head_i    (head),
    .pop_o     (pop),
    .clearing_o(clearing),
    .done_o    (done_o),
    .res_o     (res_o)
  );

endmodule
